// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("quaternion slerp assertion failed");
`define QS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("quaternion slerp implication failed");
`else
`define QS_ASSERT(lbl, clk, rstn, prop)
`define QS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/qslerp_pkg.sv
// ---------------------------------------------------------------------------
// Quaternion slerp package
// Widths, register codes, the arctangent table and the sideband record.
// ---------------------------------------------------------------------------
package qslerp_pkg;

  localparam int unsigned TRIG_ITERATIONS = 16;
  localparam int unsigned ATAN_ENTRIES    = 24;

  // CORDIC datapath widths: x/y carry Q30 values with gain headroom.
  localparam int unsigned CW = 36;
  localparam int unsigned ZW = 34;

  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned DIV_STAGES  = 62;

  localparam logic [CW-1:0] GAIN_INV = CW'(652032874);

  localparam logic REG_BLEND_MODE     = 1'b0;
  localparam logic REG_NEAR_THRESHOLD = 1'b1;

  // Operands that ride alongside the trig and divide pipelines.
  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [15:0]      t;
    logic             sph;
  } side_t;

  // atan(2^-i) in Q30, truncated.
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(843314856);
      1:  v = ZW'(497837829);
      2:  v = ZW'(263043836);
      3:  v = ZW'(133525158);
      4:  v = ZW'(67021686);
      5:  v = ZW'(33543515);
      6:  v = ZW'(16775850);
      7:  v = ZW'(8388437);
      8:  v = ZW'(4194282);
      9:  v = ZW'(2097149);
      10: v = ZW'(1048575);
      11: v = ZW'(524287);
      12: v = ZW'(262143);
      13: v = ZW'(131071);
      14: v = ZW'(65535);
      15: v = ZW'(32767);
      16: v = ZW'(16383);
      17: v = ZW'(8191);
      18: v = ZW'(4095);
      19: v = ZW'(2047);
      20: v = ZW'(1023);
      21: v = ZW'(511);
      22: v = ZW'(255);
      23: v = ZW'(127);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/quaternion_slerp_unit.sv
// ---------------------------------------------------------------------------
// Quaternion slerp unit. Throughput one transaction per cycle while the output
// is not stalled; depth is set by the 31-stage square root, two N-stage CORDIC
// chains and the 62-stage divider. rst_ni clears all valid bits asynchronously
// and loads blend_mode = 0, near_threshold = 33; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

// The datapath is one long pipeline that moves as a whole. Every stage advances
// when the output register is empty or being drained, so a stall at the master
// side freezes every stage in place and nothing is lost or repeated. The
// front end forms the dot product and sign correction, then the radicand
// 1 - c^2 feeds the square root, an arctangent CORDIC gives theta, a multiply
// stage scales it by 1-t and t, three rotation CORDICs give the sines, two
// dividers form the spherical weights, and the back end blends and saturates.
module quaternion_slerp_unit #(
  parameter int unsigned TRIG_ITERATIONS = qslerp_pkg::TRIG_ITERATIONS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Stream input. tdata from bit 0 up: start_x, start_y, start_z, start_w,
  // end_x, end_y, end_z, end_w, blend (16 bits each).
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  // Stream output. tdata from bit 0 up: out_x, out_y, out_z, out_w.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,
  // tuser: saturated.
  output logic         m_axis_tuser,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned N  = (TRIG_ITERATIONS < 1) ? 1 :
                               (TRIG_ITERATIONS > qslerp_pkg::ATAN_ENTRIES) ?
                               qslerp_pkg::ATAN_ENTRIES : TRIG_ITERATIONS;
  localparam int unsigned CW = qslerp_pkg::CW;
  localparam int unsigned ZW = qslerp_pkg::ZW;
  localparam int unsigned SW = $bits(qslerp_pkg::side_t);

  // -------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty;
  // the block itself does not enforce this, and the datapath reads them directly.
  // -------------------------------------------------------------------------
  logic        mode_q;
  logic [15:0] thr_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      thr_q  <= 16'd33;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        qslerp_pkg::REG_BLEND_MODE:     mode_q <= pwdata[0];
        qslerp_pkg::REG_NEAR_THRESHOLD: thr_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      qslerp_pkg::REG_BLEND_MODE:     prdata = {31'b0, mode_q};
      qslerp_pkg::REG_NEAR_THRESHOLD: prdata = {16'b0, thr_q};
      default:                        prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Global advance. The output register acts as the last stage; the whole
  // pipeline moves whenever it can hand its content on or is empty.
  // -------------------------------------------------------------------------
  logic en;
  logic m_vld_q;

  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // -------------------------------------------------------------------------
  // Front end: capture, products, dot product, sign correction, radicand.
  // -------------------------------------------------------------------------
  logic             vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;
  logic [3:0][15:0] a1_q, b1_q, a2_q, b2_q, a3_q, b3_q;
  logic [15:0]      t1_q, t2_q, t3_q;
  logic [3:0][31:0] p2_q;
  logic signed [33:0] dot3_q;
  qslerp_pkg::side_t side4_q, side5_q;
  logic [29:0]      c4_q, c5_q;
  logic [60:0]      rad5_q;

  logic [15:0]      blend_in;
  logic             dot_neg;
  logic [33:0]      adot;
  logic signed [35:0] near_gap;
  qslerp_pkg::side_t side4_d;

  assign blend_in = s_axis_tdata[143:128];

  always_comb begin
    dot_neg  = dot3_q[33];
    adot     = dot_neg ? 34'(-dot3_q) : 34'(dot3_q);
    near_gap = 36'sd268435456 - $signed({2'b0, adot});
    side4_d.a = a3_q;
    for (int j = 0; j < 4; j++) begin
      // -(-32768) needs the seventeenth bit.
      side4_d.b[j] = dot_neg ? 17'(-$signed({b3_q[j][15], b3_q[j]}))
                             : {b3_q[j][15], b3_q[j]};
    end
    side4_d.t   = t3_q;
    side4_d.sph = (mode_q == 1'b0) && (near_gap > $signed({7'b0, thr_q, 13'b0}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (en) begin
      vld1_q <= s_axis_tvalid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        a1_q[j] <= s_axis_tdata[16*j +: 16];
        b1_q[j] <= s_axis_tdata[64 + 16*j +: 16];
        p2_q[j] <= 32'($signed(a1_q[j]) * $signed(b1_q[j]));
      end
      // Blend factors above one act as one.
      t1_q   <= (blend_in > 16'd32768) ? 16'd32768 : blend_in;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      t2_q   <= t1_q;
      dot3_q <= $signed({{2{p2_q[0][31]}}, p2_q[0]}) + $signed({{2{p2_q[1][31]}}, p2_q[1]})
              + $signed({{2{p2_q[2][31]}}, p2_q[2]}) + $signed({{2{p2_q[3][31]}}, p2_q[3]});
      a3_q   <= a2_q;
      b3_q   <= b2_q;
      t3_q   <= t2_q;
      side4_q <= side4_d;
      // c = |dot| in Q30; only meaningful on the spherical path, where it is below one.
      c4_q   <= {adot[27:0], 2'b0};
      side5_q <= side4_q;
      c5_q   <= c4_q;
      rad5_q <= 61'(61'd1 << 60) - {1'b0, 60'(c4_q * c4_q)};
    end
  end

  // -------------------------------------------------------------------------
  // s = floor(sqrt(2^60 - c^2)), then theta = atan2(s, c).
  // -------------------------------------------------------------------------
  logic        vld_sq;
  logic [30:0] s_sq;
  logic [SW+29:0] sq_side_raw;
  qslerp_pkg::side_t side_sq;
  logic [29:0] c_sq;

  qslerp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld5_q),
    .rad_i  (rad5_q),
    .vld_o  (vld_sq),
    .root_o (s_sq)
  );

  qslerp_delay #(.WIDTH(SW + 30), .DEPTH(qslerp_pkg::SQRT_STAGES)) u_dly_sq (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i ({c5_q, side5_q}),
    .data_o (sq_side_raw)
  );

  assign side_sq = sq_side_raw[SW-1:0];
  assign c_sq    = sq_side_raw[SW+29:SW];

  logic                 vld_at;
  logic signed [CW-1:0] y_at_unused;
  logic signed [ZW-1:0] z_at;
  qslerp_pkg::side_t    side_at;

  qslerp_cordic #(.N(N), .VECTORING(1'b1)) u_atan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_sq),
    .x_i    ($signed({6'b0, c_sq})),
    .y_i    ($signed({5'b0, s_sq})),
    .z_i    ('0),
    .vld_o  (vld_at),
    .y_o    (y_at_unused),
    .z_o    (z_at)
  );

  qslerp_delay #(.WIDTH(SW), .DEPTH(N)) u_dly_at (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (side_sq),
    .data_o (side_at)
  );

  // -------------------------------------------------------------------------
  // Angle split: phi0 = theta*(1-t), phi1 = theta*t, theta clamped at zero.
  // -------------------------------------------------------------------------
  logic              vldm_q;
  logic [ZW-1:0]     thm_q, phi0_q, phi1_q;
  qslerp_pkg::side_t sidem_q;
  logic [32:0]       th_pos;
  logic [16:0]       omt_at;
  logic [49:0]       prod0, prod1;

  always_comb begin
    th_pos = z_at[ZW-1] ? '0 : z_at[32:0];
    omt_at = 17'd32768 - {1'b0, side_at.t};
    prod0  = th_pos * omt_at;
    prod1  = th_pos * {1'b0, side_at.t};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldm_q <= 1'b0;
    end else if (en) begin
      vldm_q <= vld_at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      thm_q   <= {1'b0, th_pos};
      phi0_q  <= {1'b0, prod0[47:15]};
      phi1_q  <= {1'b0, prod1[47:15]};
      sidem_q <= side_at;
    end
  end

  // -------------------------------------------------------------------------
  // Three sine rotations in parallel.
  // -------------------------------------------------------------------------
  logic                 vld_s, vld_s0_unused, vld_s1_unused;
  logic signed [CW-1:0] ds, n0, n1;
  logic signed [ZW-1:0] zr_unused0, zr_unused1, zr_unused2;
  qslerp_pkg::side_t    side_s;

  qslerp_cordic #(.N(N), .VECTORING(1'b0)) u_sin_th (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .vld_i (vldm_q),
    .x_i   ($signed(qslerp_pkg::GAIN_INV)), .y_i ('0), .z_i ($signed(thm_q)),
    .vld_o (vld_s), .y_o (ds), .z_o (zr_unused0)
  );

  qslerp_cordic #(.N(N), .VECTORING(1'b0)) u_sin_p0 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .vld_i (vldm_q),
    .x_i   ($signed(qslerp_pkg::GAIN_INV)), .y_i ('0), .z_i ($signed(phi0_q)),
    .vld_o (vld_s0_unused), .y_o (n0), .z_o (zr_unused1)
  );

  qslerp_cordic #(.N(N), .VECTORING(1'b0)) u_sin_p1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .vld_i (vldm_q),
    .x_i   ($signed(qslerp_pkg::GAIN_INV)), .y_i ('0), .z_i ($signed(phi1_q)),
    .vld_o (vld_s1_unused), .y_o (n1), .z_o (zr_unused2)
  );

  qslerp_delay #(.WIDTH(SW), .DEPTH(N)) u_dly_sin (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (sidem_q),
    .data_o (side_s)
  );

  // -------------------------------------------------------------------------
  // Divider operands. A sine of theta that is zero or negative falls back to
  // the linear weights.
  // -------------------------------------------------------------------------
  logic              vldd_q, neg0_q, neg1_q;
  logic [31:0]       mag0_q, mag1_q, den_q;
  qslerp_pkg::side_t sided_q, sided_d;
  logic [CW-1:0]     abs0, abs1;

  always_comb begin
    abs0        = n0[CW-1] ? CW'(-n0) : CW'(n0);
    abs1        = n1[CW-1] ? CW'(-n1) : CW'(n1);
    sided_d     = side_s;
    sided_d.sph = side_s.sph && (ds > 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldd_q <= 1'b0;
    end else if (en) begin
      vldd_q <= vld_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag0_q  <= abs0[31:0];
      mag1_q  <= abs1[31:0];
      neg0_q  <= n0[CW-1];
      neg1_q  <= n1[CW-1];
      den_q   <= ds[31:0];
      sided_q <= sided_d;
    end
  end

  logic               vld_v, vld_v1_unused;
  logic signed [63:0] q0, q1;
  qslerp_pkg::side_t  side_v;

  qslerp_div u_div0 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .vld_i (vldd_q),
    .mag_i (mag0_q), .neg_i (neg0_q), .den_i (den_q),
    .vld_o (vld_v), .quo_o (q0)
  );

  qslerp_div u_div1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .vld_i (vldd_q),
    .mag_i (mag1_q), .neg_i (neg1_q), .den_i (den_q),
    .vld_o (vld_v1_unused), .quo_o (q1)
  );

  qslerp_delay #(.WIDTH(SW), .DEPTH(qslerp_pkg::DIV_STAGES)) u_dly_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (sided_q),
    .data_o (side_v)
  );

  // -------------------------------------------------------------------------
  // Back end: weight select, partial products, sum and round, saturate.
  // Products are kept modulo 2^64 as 64-bit weights times components.
  // -------------------------------------------------------------------------
  logic              vldk_q, vldp_q, vlds_q;
  logic [63:0]       k0_q, k1_q;
  qslerp_pkg::side_t sidek_q;
  logic [16:0]       omt_v;
  logic [3:0][48:0]  lo0_q;
  logic [3:0][49:0]  lo1_q;
  logic [3:0][31:0]  hi0_q, hi1_q;
  logic [3:0][63:0]  sum_q;
  logic [3:0][15:0]  res;
  logic [3:0]        clip;

  assign omt_v = 17'd32768 - {1'b0, side_v.t};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      clip[j] = (sum_q[j][63:46] != {18{sum_q[j][45]}});
      res[j]  = clip[j] ? (sum_q[j][63] ? 16'h8000 : 16'h7fff) : sum_q[j][45:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldk_q  <= 1'b0;
      vldp_q  <= 1'b0;
      vlds_q  <= 1'b0;
      m_vld_q <= 1'b0;
    end else if (en) begin
      vldk_q  <= vld_v;
      vldp_q  <= vldk_q;
      vlds_q  <= vldp_q;
      m_vld_q <= vlds_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k0_q    <= side_v.sph ? q0 : {32'b0, omt_v, 15'b0};
      k1_q    <= side_v.sph ? q1 : {33'b0, side_v.t, 15'b0};
      sidek_q <= side_v;
      for (int j = 0; j < 4; j++) begin
        lo0_q[j] <= $signed({1'b0, k0_q[31:0]}) * $signed(sidek_q.a[j]);
        hi0_q[j] <= 32'($signed(k0_q[63:32]) * $signed(sidek_q.a[j]));
        lo1_q[j] <= $signed({1'b0, k1_q[31:0]}) * $signed(sidek_q.b[j]);
        hi1_q[j] <= 32'($signed(k1_q[63:32]) * $signed(sidek_q.b[j]));
        // Adding one half before the floor shift rounds half up.
        sum_q[j] <= {{15{lo0_q[j][48]}}, lo0_q[j]} + {{14{lo1_q[j][49]}}, lo1_q[j]}
                  + {32'(hi0_q[j] + hi1_q[j]), 32'b0} + 64'd536870912;
      end
      m_axis_tdata <= {res[3], res[2], res[1], res[0]};
      m_axis_tuser <= |clip;
    end
  end

  assign m_axis_tvalid = m_vld_q;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `QS_ASSERT_IMPL(a_sat_at_rail, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata[15:0] == 16'h7fff || m_axis_tdata[15:0] == 16'h8000 ||
    m_axis_tdata[31:16] == 16'h7fff || m_axis_tdata[31:16] == 16'h8000 ||
    m_axis_tdata[47:32] == 16'h7fff || m_axis_tdata[47:32] == 16'h8000 ||
    m_axis_tdata[63:48] == 16'h7fff || m_axis_tdata[63:48] == 16'h8000)
  `QS_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)
  `QS_ASSERT(a_linear_weights_sum_one, clk_i, rst_ni,
    (vldk_q && !sidek_q.sph) |-> (k0_q + k1_q == 64'd1073741824))

endmodule

// File: src/qslerp_delay.sv
// ---------------------------------------------------------------------------
// Quaternion slerp delay line
// Enabled shift register that keeps sideband data aligned with a unit.
// ---------------------------------------------------------------------------
module qslerp_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tap_q[k] <= (k == 0) ? data_i : tap_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

// File: src/qslerp_isqrt.sv
// ---------------------------------------------------------------------------
// Quaternion slerp square root
// Pipelined restoring integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module qslerp_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [60:0] rad_i,
  output logic        vld_o,
  output logic [30:0] root_o
);

  localparam int unsigned S = qslerp_pkg::SQRT_STAGES;

  logic [61:0] rem_q  [S];
  logic [30:0] root_q [S];
  logic        vld_q  [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    localparam int unsigned B = S - 1 - k;
    logic [61:0] rem_in, trial, rem_d;
    logic [30:0] root_in, root_d;
    logic        vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, rad_i};
      assign root_in = '0;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    always_comb begin
      trial = ({31'b0, root_in} << (B + 1)) + (62'd1 << (2 * B));
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (31'd1 << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign vld_o  = vld_q[S-1];
  assign root_o = root_q[S-1];

endmodule

// File: src/qslerp_cordic.sv
// ---------------------------------------------------------------------------
// Quaternion slerp CORDIC
// Unrolled CORDIC, one micro-rotation per stage, vectoring or rotation.
// ---------------------------------------------------------------------------
module qslerp_cordic #(
  parameter int unsigned N         = 16,
  parameter bit          VECTORING = 1'b0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic signed [qslerp_pkg::CW-1:0]    x_i,
  input  logic signed [qslerp_pkg::CW-1:0]    y_i,
  input  logic signed [qslerp_pkg::ZW-1:0]    z_i,
  output logic                                vld_o,
  output logic signed [qslerp_pkg::CW-1:0]    y_o,
  output logic signed [qslerp_pkg::ZW-1:0]    z_o
);

  localparam int unsigned CW = qslerp_pkg::CW;
  localparam int unsigned ZW = qslerp_pkg::ZW;

  logic signed [CW-1:0] x_q [N];
  logic signed [CW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  logic                 vld_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [CW-1:0] xi, yi, dx, dy, x_d, y_d;
    logic signed [ZW-1:0] zi, z_d;
    logic                 vi, sig;

    if (k == 0) begin : g_first
      assign xi = x_i;
      assign yi = y_i;
      assign zi = z_i;
      assign vi = vld_i;
    end else begin : g_next
      assign xi = x_q[k-1];
      assign yi = y_q[k-1];
      assign zi = z_q[k-1];
      assign vi = vld_q[k-1];
    end

    // Vectoring drives y toward zero; rotation drives z toward zero.
    always_comb begin
      dx  = yi >>> k;
      dy  = xi >>> k;
      sig = VECTORING ? yi[CW-1] : !zi[ZW-1];
      if (sig) begin
        x_d = xi - dx;
        y_d = yi + dy;
        z_d = zi - qslerp_pkg::atan_q30(k);
      end else begin
        x_d = xi + dx;
        y_d = yi - dy;
        z_d = zi + qslerp_pkg::atan_q30(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k] <= x_d;
        y_q[k] <= y_d;
        z_q[k] <= z_d;
      end
    end
  end

  assign vld_o = vld_q[N-1];
  assign y_o   = y_q[N-1];
  assign z_o   = z_q[N-1];

endmodule

// File: src/qslerp_div.sv
// ---------------------------------------------------------------------------
// Quaternion slerp divider
// Pipelined restoring divider for (mag * 2^30) / den, one quotient bit per stage.
// ---------------------------------------------------------------------------
module qslerp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [31:0]        mag_i,
  input  logic               neg_i,
  input  logic [31:0]        den_i,
  output logic               vld_o,
  output logic signed [63:0] quo_o
);

  localparam int unsigned S = qslerp_pkg::DIV_STAGES;

  logic [31:0]  rem_q [S];
  logic [S-1:0] dvd_q [S];
  logic [S-1:0] quo_q [S];
  logic [31:0]  den_q [S];
  logic         neg_q [S];
  logic         vld_q [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [31:0]  rem_in, den_in, rem_d;
    logic [S-1:0] dvd_in, quo_in;
    logic         neg_in, vld_in;
    logic [32:0]  part;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = {mag_i, 30'b0};
      assign quo_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    always_comb begin
      part = {rem_in, dvd_in[S-1]};
      if (part >= {1'b0, den_in}) begin
        rem_d = 32'(part - {1'b0, den_in});
      end else begin
        rem_d = part[31:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        dvd_q[k] <= {dvd_in[S-2:0], 1'b0};
        quo_q[k] <= {quo_in[S-2:0], (part >= {1'b0, den_in})};
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  // Truncation toward zero: divide magnitudes, then restore the sign.
  assign vld_o = vld_q[S-1];
  assign quo_o = neg_q[S-1] ? -$signed({2'b0, quo_q[S-1]}) : $signed({2'b0, quo_q[S-1]});

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Quaternion slerp unit testbench
// Drives quaternion pairs and blend factors through the stream input, writes
// the mode and threshold registers between phases, and compares every output
// transaction with a bit-exact fixed-point slerp/lerp predictor or a known value.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LATENCY   = 104 + 2 * qslerp_pkg::TRIG_ITERATIONS;
  localparam int unsigned WATCHDOG  = 20000;
  localparam logic [2:0]  ADDR_MODE = 3'(4 * qslerp_pkg::REG_BLEND_MODE);
  localparam logic [2:0]  ADDR_THR  = 3'(4 * qslerp_pkg::REG_NEAR_THRESHOLD);

  typedef struct packed {
    logic [15:0] qx, qy, qz, qw;
    logic        sat;
  } quat_out_t;

  typedef struct {
    logic [15:0] f[9];
    bit          known;
    quat_out_t   res;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  quaternion_slerp_unit u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor copy of the two registers.
  logic        mode_q = 1'b0;
  logic [15:0] thr_q  = 16'd33;

  quat_out_t   expected_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_off = 1'b0;

  function automatic longint asr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint atan_tab(int i);
    longint tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    return tab[i];
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic int trig_steps();
    int n = qslerp_pkg::TRIG_ITERATIONS;
    if (n < 1) n = 1;
    if (n > 24) n = 24;
    return n;
  endfunction

  function automatic longint vec_angle(longint x, longint y);
    longint z = 0, dx, dy;
    for (int i = 0; i < trig_steps(); i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab(i);
      end else begin
        x -= dx; y += dy; z -= atan_tab(i);
      end
    end
    return z;
  endfunction

  function automatic longint rot_sine(longint z);
    longint x = 652032874, y = 0, dx, dy;
    for (int i = 0; i < trig_steps(); i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab(i);
      end else begin
        x += dx; y -= dy; z += atan_tab(i);
      end
    end
    return y;
  endfunction

  function automatic quat_out_t interp(logic [15:0] f[9]);
    longint a[4], b[4], dot = 0, k0, k1, t, c, s, th, ds, n0, n1, v;
    quat_out_t r;
    logic [15:0] o[4];
    r.sat = 1'b0;
    t = longint'(f[8]);
    if (t > 32768) t = 32768;
    for (int j = 0; j < 4; j++) begin
      a[j] = longint'($signed(f[j]));
      b[j] = longint'($signed(f[4 + j]));
      dot += a[j] * b[j];
    end
    if (dot < 0) begin
      dot = -dot;
      for (int j = 0; j < 4; j++) b[j] = -b[j];
    end
    k0 = (32768 - t) * 32768;
    k1 = t * 32768;
    if (!mode_q && ((64'sd1 << 28) - dot) > longint'(thr_q) * 8192) begin
      c = dot * 4;
      s = root64((64'd1 << 60) - longint'(c) * longint'(c));
      th = vec_angle(c, s);
      if (th < 0) th = 0;
      ds = rot_sine(th);
      if (ds > 0) begin
        n0 = rot_sine((th * (32768 - t)) >>> 15);
        n1 = rot_sine((th * t) >>> 15);
        k0 = (n0 * (64'sd1 << 30)) / ds;
        k1 = (n1 * (64'sd1 << 30)) / ds;
      end
    end
    for (int j = 0; j < 4; j++) begin
      v = asr(k0 * a[j] + k1 * b[j] + (64'sd1 << 29), 30);
      if (v > 32767) begin v = 32767; r.sat = 1'b1; end
      if (v < -32768) begin v = -32768; r.sat = 1'b1; end
      o[j] = v[15:0];
    end
    r.qx = o[0]; r.qy = o[1]; r.qz = o[2]; r.qw = o[3];
    return r;
  endfunction

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_MODE) mode_q = data[0];
    else thr_q = data[15:0];
  endtask

  // Stop offering and wait for the pipeline to drain before touching the registers.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Sends one transaction; the expectation is queued at acceptance. The valid
  // stays high after acceptance so that transactions can follow back to back.
  task automatic send_item(logic [15:0] f[9], bit known, quat_out_t res);
    while (!no_idle && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {f[8], f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(known ? res : interp(f));
  endtask

  // Random pair: a fifth are small quaternions close together, most are raw noise.
  task automatic rand_item(output logic [15:0] f[9]);
    int kind = $urandom_range(9);
    for (int j = 0; j < 4; j++) begin
      if (kind < 3) begin
        f[j] = 16'($urandom_range(16384) - 8192);
      end else begin
        f[j] = 16'($urandom);
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (kind < 2) f[4 + j] = f[j] + 16'($urandom_range(400) - 200);
      else f[4 + j] = 16'($urandom);
    end
    case ($urandom_range(5))
      0: f[8] = 16'($urandom);
      1: f[8] = 16'd32768;
      2: f[8] = 16'd0;
      default: f[8] = 16'($urandom_range(32768));
    endcase
  endtask

  // Output side: random stalls, plus one long hold-off requested by the sender.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_idle || ($urandom_range(99) >= 34);
  end

  always @(posedge clk_i) begin
    quat_out_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
              m_axis_tdata[63:48], m_axis_tuser};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected %h got %h", exp_r, got);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int hold_len;
    hold_len = 400;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_len--;
        if (hold_len == 0) hold_off <= 1'b0;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    logic [15:0] f[9];
    quat_out_t none;
    logic [15:0] thr_set[4];
    thr_set = '{16'd0, 16'd33, 16'd32768, 16'hFFFF};
    none = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table. Identical unit quaternions hit the near-parallel lerp
    // path, so half the start plus half the end is read off directly.
    r.known = 1'b1;
    r.f = '{16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd16384};
    r.res = '{16'd0, 16'd0, 16'd0, 16'd16384, 1'b0};
    rows.push_back(r);
    // All zero inputs give zero output.
    r.f = '{default: 16'd0};
    r.res = '0;
    rows.push_back(r);
    // Full scale negative pair at t = 0 saturates nothing: a is passed.
    r.f = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 16'd0};
    r.known = 1'b0;
    rows.push_back(r);
    r.known = 1'b0;
    // Blend above one, negative dot with minimum components, orthogonal pair.
    r.f = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
            16'h7FFF, 16'hFFFF};
    rows.push_back(r);
    r.f = '{16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd16384};
    rows.push_back(r);
    r.f = '{16'd16384, 16'd0, 16'd0, 16'd0, 16'hC000, 16'd0, 16'd0, 16'd0, 16'd8192};
    rows.push_back(r);
    r.f = '{16'd11585, 16'd11585, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd100};
    rows.push_back(r);
    r.f = '{16'd16384, 16'd0, 16'd0, 16'd0, 16'd16380, 16'd300, 16'd0, 16'd0, 16'd20000};
    rows.push_back(r);
    r.f = '{16'h8000, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd32768};
    rows.push_back(r);
    r.f = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
            16'h5555, 16'h5555};
    rows.push_back(r);
    r.f = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd16384};
    rows.push_back(r);
    foreach (rows[i]) send_item(rows[i].f, rows[i].known, rows[i].res);
    drain();

    // Linear mode on the same table, then phases with random content.
    reg_write(ADDR_MODE, 32'd1);
    foreach (rows[i]) send_item(rows[i].f, 1'b0, none);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(ADDR_MODE, 32'(ph == 5));
      reg_write(ADDR_THR, 32'(thr_set[ph % 4]) | ({$urandom} & 32'hFFFF0000));
      no_idle = (ph == 2);
      for (int k = 0; k < 250; k++) begin
        if (ph == 1 && k == 20) hold_off <= 1'b1;
        rand_item(f);
        send_item(f, 1'b0, none);
      end
      drain();
    end
    no_idle = 1'b0;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/qslerp_pkg.sv
src/qslerp_delay.sv
src/qslerp_isqrt.sv
src/qslerp_cordic.sv
src/qslerp_div.sv
src/quaternion_slerp_unit.sv
tb/sv/tb_top.sv
